### src/dcmc_pkg.sv
// Shared types, character codes and segment patterns for the DC motor command controller.
package dcmc_pkg;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_SERIAL = 2'd1,
        KIND_SWITCH = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ACK_NONE    = 3'd0,
        ACK_PLUS    = 3'd1,
        ACK_MINUS   = 3'd2,
        ACK_REVERSE = 3'd3,
        ACK_PAUSE   = 3'd4,
        ACK_LOCAL   = 3'd5,
        ACK_REMOTE  = 3'd6,
        ACK_REPORT  = 3'd7
    } ack_t;

    typedef enum logic [0:0] {
        CFG_REVERSAL_DELAY = 1'd0,
        CFG_RESUME_SPEED   = 1'd1
    } cfg_index_t;

    localparam logic [7:0] CHAR_PLUS      = 8'h2B;
    localparam logic [7:0] CHAR_MINUS     = 8'h2D;
    localparam logic [7:0] CHAR_I_UPPER   = 8'h49;
    localparam logic [7:0] CHAR_I_LOWER   = 8'h69;
    localparam logic [7:0] CHAR_P_UPPER   = 8'h50;
    localparam logic [7:0] CHAR_P_LOWER   = 8'h70;
    localparam logic [7:0] CHAR_S_UPPER   = 8'h53;
    localparam logic [7:0] CHAR_S_LOWER   = 8'h73;
    localparam logic [7:0] CHAR_D_UPPER   = 8'h44;
    localparam logic [7:0] CHAR_D_LOWER   = 8'h64;
    localparam logic [7:0] CHAR_B_UPPER   = 8'h42;
    localparam logic [7:0] CHAR_B_LOWER   = 8'h62;

    localparam logic [3:0] SW_UP          = 4'hE;
    localparam logic [3:0] SW_DOWN        = 4'hD;
    localparam logic [3:0] SW_REVERSE     = 4'hB;
    localparam logic [3:0] SW_PAUSE       = 4'h7;

    localparam logic [6:0] SPEED_MAX      = 7'd100;
    localparam logic [6:0] SPEED_STEP     = 7'd5;
    localparam logic [6:0] SPEED_SHOW_MIN = 7'd95;
    localparam logic [6:0] SPEED_SHOW_CAP = 7'd99;
    localparam logic [6:0] SPEED_RESET    = 7'd50;

    localparam logic [7:0] DELAY_RESET    = 8'd100;
    localparam logic [7:0] DUTY_RESET     = 8'd128;

    localparam logic [7:0] SEG_MINUS      = 8'hBF;
    localparam logic [7:0] SEG_BLANK      = 8'hFF;
    localparam logic [7:0] SEG_LOCAL      = 8'h92;
    localparam logic [7:0] SEG_REMOTE     = 8'hA1;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
        logic       rx_error;
        logic [3:0] switches;
    } item_t;

    typedef struct packed {
        logic [6:0] speed_pct;
        logic [6:0] saved_speed;
        logic       paused;
        logic       reversing;
        logic       direction;
        logic       line_a;
        logic       line_b;
        logic       local_mode;
        logic       switch_held;
        logic [7:0] delay_count;
        logic       delay_done;
        logic [1:0] digit_sel;
        logic [7:0] last_segments;
        logic [7:0] last_duty;
    } state_t;

    typedef struct packed {
        logic [7:0] segments;
        logic [7:0] duty;
    } disp_t;

    function automatic logic [7:0] seg_of_digit(input logic [3:0] d);
        logic [7:0] seg;
        case (d)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

### src/dcmc_disp.sv
// Display digit selection and PWM duty computation from the current speed.
module dcmc_disp (
    input  logic [6:0]      speed_pct,
    input  logic            direction,
    input  logic            local_mode,
    input  logic [1:0]      digit_sel,
    output dcmc_pkg::disp_t disp
);
    import dcmc_pkg::*;

    logic [6:0]  shown;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  units_wide;
    logic [14:0] scaled;
    logic [27:0] duty_prod;

    // Tens digit by multiplying with 205/2048, exact for values below 100.
    assign shown      = (speed_pct >= SPEED_SHOW_MIN) ? SPEED_SHOW_CAP : speed_pct;
    assign tens_prod  = {8'd0, shown} * 15'd205;
    assign tens       = tens_prod[14:11];
    assign tens_x10   = {3'd0, tens} * 7'd10;
    assign units_wide = shown - tens_x10;

    // Duty is 255 * speed / 100, the division done as a multiply by 5243/2^19.
    assign scaled     = {speed_pct, 8'd0} - {8'd0, speed_pct};
    assign duty_prod  = {13'd0, scaled} * 28'd5243;

    always_comb begin
        case (digit_sel)
            2'd0:    disp.segments = seg_of_digit(units_wide[3:0]);
            2'd1:    disp.segments = seg_of_digit(tens);
            2'd2:    disp.segments = direction ? SEG_MINUS : SEG_BLANK;
            default: disp.segments = local_mode ? SEG_LOCAL : SEG_REMOTE;
        endcase
        disp.duty = duty_prod[26:19];
    end

endmodule

### src/dcmc_core.sv
// Next-state and acknowledge logic for one tick, serial byte or switch sample.
module dcmc_core (
    input  dcmc_pkg::state_t cur,
    input  dcmc_pkg::item_t  item,
    input  logic [7:0]       reversal_delay,
    input  logic [6:0]       resume_speed,
    output dcmc_pkg::state_t nxt,
    output dcmc_pkg::ack_t   ack
);
    import dcmc_pkg::*;

    disp_t      disp;
    logic [7:0] up_sum;
    logic [6:0] speed_up;
    logic [6:0] speed_down;
    logic [6:0] resume_clamped;
    logic [7:0] count_dec;
    logic       done_now;

    dcmc_disp u_disp (
        .speed_pct  (cur.speed_pct),
        .direction  (cur.direction),
        .local_mode (cur.local_mode),
        .digit_sel  (cur.digit_sel),
        .disp       (disp)
    );

    assign up_sum         = {1'b0, cur.speed_pct} + {1'b0, SPEED_STEP};
    assign speed_up       = (cur.speed_pct >= SPEED_MAX) ? cur.speed_pct :
                            (up_sum > {1'b0, SPEED_MAX}) ? SPEED_MAX : up_sum[6:0];
    assign speed_down     = (cur.speed_pct >= SPEED_STEP) ? (cur.speed_pct - SPEED_STEP)
                                                          : cur.speed_pct;
    assign resume_clamped = (resume_speed > SPEED_MAX) ? SPEED_MAX : resume_speed;
    assign count_dec      = cur.delay_count - 8'd1;
    assign done_now       = cur.delay_done || (count_dec == 8'd0);

    function automatic state_t start_reversal(input state_t s, input logic [7:0] dly);
        state_t r;
        r = s;
        if (!s.paused && !s.reversing) begin
            r.reversing   = 1'b1;
            r.direction   = !s.line_b;
            r.saved_speed = s.speed_pct;
            r.line_a      = 1'b1;
            r.line_b      = 1'b1;
            r.delay_count = dly;
            r.speed_pct   = 7'd0;
            r.delay_done  = 1'b0;
        end
        return r;
    endfunction

    function automatic state_t toggle_pause(input state_t s, input logic [6:0] resume);
        state_t r;
        r = s;
        if (!s.paused) begin
            r.paused    = 1'b1;
            r.speed_pct = 7'd0;
        end else begin
            r.paused    = 1'b0;
            r.speed_pct = resume;
        end
        return r;
    endfunction

    always_comb begin
        nxt = cur;
        ack = ACK_NONE;
        case (kind_t'(item.mode))
            KIND_TICK: begin
                nxt.delay_count   = count_dec;
                nxt.delay_done    = done_now;
                nxt.last_segments = disp.segments;
                nxt.digit_sel     = cur.digit_sel + 2'd1;
                nxt.last_duty     = disp.duty;
                if (!cur.paused && cur.reversing && done_now) begin
                    if (!cur.direction) begin
                        nxt.line_b    = 1'b0;
                        nxt.direction = 1'b1;
                    end else begin
                        nxt.line_a    = 1'b0;
                        nxt.direction = 1'b0;
                    end
                    nxt.reversing = 1'b0;
                    nxt.speed_pct = cur.saved_speed;
                end
            end
            KIND_SERIAL: begin
                if (!item.rx_error) begin
                    case (item.rx_byte)
                        CHAR_PLUS: begin
                            if (!cur.local_mode) begin
                                if (cur.speed_pct < SPEED_MAX) begin
                                    nxt.paused    = 1'b0;
                                    nxt.speed_pct = speed_up;
                                end
                                ack = ACK_PLUS;
                            end
                        end
                        CHAR_MINUS: begin
                            if (!cur.local_mode) begin
                                nxt.speed_pct = speed_down;
                                ack = ACK_MINUS;
                            end
                        end
                        CHAR_I_UPPER, CHAR_I_LOWER: begin
                            if (!cur.local_mode) begin
                                nxt = start_reversal(cur, reversal_delay);
                                ack = ACK_REVERSE;
                            end
                        end
                        CHAR_P_UPPER, CHAR_P_LOWER: begin
                            if (!cur.local_mode) begin
                                nxt = toggle_pause(cur, resume_clamped);
                                ack = ACK_PAUSE;
                            end
                        end
                        CHAR_S_UPPER, CHAR_S_LOWER: begin
                            nxt.local_mode = 1'b1;
                            ack = ACK_LOCAL;
                        end
                        CHAR_D_UPPER, CHAR_D_LOWER: begin
                            nxt.local_mode = 1'b0;
                            ack = ACK_REMOTE;
                        end
                        CHAR_B_UPPER, CHAR_B_LOWER: begin
                            nxt.saved_speed = cur.speed_pct;
                            ack = ACK_REPORT;
                        end
                        default: ack = ACK_NONE;
                    endcase
                end
            end
            KIND_SWITCH: begin
                if (cur.local_mode) begin
                    case (item.switches)
                        SW_UP: begin
                            if (!cur.switch_held) begin
                                nxt.switch_held = 1'b1;
                                nxt.paused      = 1'b0;
                                nxt.speed_pct   = speed_up;
                            end
                        end
                        SW_DOWN: begin
                            if (!cur.switch_held) begin
                                nxt.switch_held = 1'b1;
                                nxt.speed_pct   = speed_down;
                            end
                        end
                        SW_REVERSE: begin
                            if (!cur.switch_held) begin
                                nxt             = start_reversal(cur, reversal_delay);
                                nxt.switch_held = 1'b1;
                            end
                        end
                        SW_PAUSE: begin
                            if (!cur.switch_held) begin
                                nxt             = toggle_pause(cur, resume_clamped);
                                nxt.switch_held = 1'b1;
                            end
                        end
                        default: nxt.switch_held = 1'b0;
                    endcase
                end
            end
            default: nxt = cur;
        endcase
    end

endmodule

### src/dc_motor_command_controller_top.sv
// Top level of the DC motor command controller with request and result registers.
// A request is registered at acceptance, and its result is registered when the request advances.
// Throughput: one request per cycle unless m_ready stalls, set by the single state update.
// A waiting result lets one more request into the input register, then holds s_ready low.
// Reset (aresetn low, synchronous) restores the speed of 50, remote mode, braking line B,
// both configuration registers to their defaults, and empties both registers.
module dc_motor_command_controller_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [0:0] cfg_wr_index,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_rx_byte,
    input  logic       s_rx_error,
    input  logic [3:0] s_switches,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_pwm_duty,
    output logic       m_drive_a,
    output logic       m_drive_b,
    output logic [1:0] m_digit_index,
    output logic [7:0] m_segments,
    output logic [2:0] m_ack_code,
    output logic [6:0] m_speed,
    output logic       m_reverse_dir,
    output logic       m_local_control
);
    import dcmc_pkg::*;

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    state_t     state_reg;
    state_t     state_next;
    ack_t       ack_next;
    logic [7:0] rev_delay_reg;
    logic [6:0] resume_speed_reg;
    logic       advance;

    dcmc_core u_core (
        .cur            (state_reg),
        .item           (in_item_reg),
        .reversal_delay (rev_delay_reg),
        .resume_speed   (resume_speed_reg),
        .nxt            (state_next),
        .ack            (ack_next)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            rev_delay_reg         <= DELAY_RESET;
            resume_speed_reg      <= SPEED_RESET;
            state_reg.speed_pct   <= SPEED_RESET;
            state_reg.saved_speed <= SPEED_RESET;
            state_reg.paused      <= 1'b0;
            state_reg.reversing   <= 1'b0;
            state_reg.direction   <= 1'b0;
            state_reg.line_a      <= 1'b0;
            state_reg.line_b      <= 1'b1;
            state_reg.local_mode  <= 1'b0;
            state_reg.switch_held <= 1'b0;
            state_reg.delay_count <= DELAY_RESET;
            state_reg.delay_done  <= 1'b0;
            state_reg.digit_sel   <= 2'd0;
            state_reg.last_segments <= SEG_BLANK;
            state_reg.last_duty   <= DUTY_RESET;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_wr_index))
                    CFG_REVERSAL_DELAY: rev_delay_reg    <= cfg_wr_data;
                    CFG_RESUME_SPEED:   resume_speed_reg <= cfg_wr_data[6:0];
                    default:            rev_delay_reg    <= rev_delay_reg;
                endcase
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.mode     <= s_mode;
            in_item_reg.rx_byte  <= s_rx_byte;
            in_item_reg.rx_error <= s_rx_error;
            in_item_reg.switches <= s_switches;
        end
        if (advance) begin
            m_pwm_duty      <= state_next.last_duty;
            m_drive_a       <= state_next.line_a;
            m_drive_b       <= state_next.line_b;
            m_digit_index   <= state_next.digit_sel - 2'd1;
            m_segments      <= state_next.last_segments;
            m_ack_code      <= ack_next;
            m_speed         <= state_next.speed_pct;
            m_reverse_dir   <= state_next.direction;
            m_local_control <= state_next.local_mode;
        end
    end

endmodule
